### hw/rtl/rpls_pkg.sv
// Shared constants and types for the row projection line segmenter.
// No dependencies; imported by the loader, scanner, core and bench.
`default_nettype none
package rpls_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;

  localparam int ADDR_W    = $clog2(MAX_ROWS);
  localparam int ROW_W     = $clog2(MAX_ROWS + 1);
  localparam int CNT_W     = $clog2(MAX_COLS + 1);
  localparam int WT_W      = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int RATIO_W   = 6;
  localparam int OUT_ROW_W = 10;

  localparam int PROD_W    = CNT_W + ROW_W;
  localparam int LHS_W     = PROD_W + 4;
  localparam int RHS_W     = RATIO_W + WT_W;
  localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(11);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_READ,
    SC_MULT,
    SC_TEST
  } scan_state_e;

  typedef struct packed {
    logic             loaded;
    logic [ROW_W-1:0] row_total;
    logic [WT_W-1:0]  white_total;
    logic             scan_clr;
  } ldr_status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } ram_wr_t;

endpackage
`default_nettype wire

### hw/rtl/rpls_chan_if.sv
// Valid/ready channels for request words and result words.
// No dependencies.
`default_nettype none
interface rpls_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic pixel_white;
  logic row_end;
  logic image_end;

  modport source (output valid, req_type, pixel_white, row_end, image_end, input ready);
  modport sink   (input valid, req_type, pixel_white, row_end, image_end, output ready);
endinterface

interface rpls_res_if;
  logic       valid;
  logic       ready;
  logic       has_segment;
  logic [9:0] first_row;
  logic [9:0] last_row;
  logic       scan_done;

  modport source (output valid, has_segment, first_row, last_row, scan_done, input ready);
  modport sink   (input valid, has_segment, first_row, last_row, scan_done, output ready);
endinterface
`default_nettype wire

### hw/rtl/rpls_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module rpls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rpls_loader.sv
// Pixel loader: counts white pixels of the current row, keeps totals,
// and writes each closed row's count to the row count RAM. Uses rpls_pkg.
`default_nettype none
module rpls_loader (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pix_fire_i,
  input  wire logic                 pixel_white_i,
  input  wire logic                 row_end_i,
  input  wire logic                 image_end_i,
  output rpls_pkg::ram_wr_t         ram_wr_o,
  output rpls_pkg::ldr_status_t     status_o
);
  import rpls_pkg::*;

  logic             loaded_q, loaded_d;
  logic [ROW_W-1:0] rt_q, rt_d;
  logic [WT_W-1:0]  wt_q, wt_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [ROW_W-1:0] rt_eff;
  logic [WT_W-1:0]  wt_eff;
  logic [CNT_W-1:0] col_eff;
  logic [CNT_W-1:0] cnt_base;

  // a pixel after a finished image starts a new one
  assign rt_eff  = loaded_q ? '0 : rt_q;
  assign wt_eff  = loaded_q ? '0 : wt_q;
  assign col_eff = loaded_q ? '0 : col_q;
  assign cnt_base = (col_eff == '0) ? '0 : cnt_q;

  always_comb begin
    loaded_d = loaded_q;
    rt_d     = rt_q;
    wt_d     = wt_q;
    col_d    = col_q;
    cnt_d    = cnt_q;
    ram_wr_o = '0;
    if (pix_fire_i) begin
      loaded_d = 1'b0;
      rt_d     = rt_eff;
      wt_d     = wt_eff;
      col_d    = col_eff;
      cnt_d    = cnt_base;
      if (rt_eff < ROW_W'(MAX_ROWS)) begin
        if (col_eff < CNT_W'(MAX_COLS)) begin
          col_d = col_eff + CNT_W'(1);
          if (pixel_white_i && (cnt_base < CNT_W'(MAX_COLS))) begin
            cnt_d = cnt_base + CNT_W'(1);
            wt_d  = wt_eff + WT_W'(1);
          end
        end
        // image end always closes a row here: this pixel made it non-empty
        if (row_end_i || image_end_i) begin
          ram_wr_o.we   = 1'b1;
          ram_wr_o.addr = ADDR_W'(rt_eff);
          ram_wr_o.data = cnt_d;
          rt_d          = rt_eff + ROW_W'(1);
          col_d         = '0;
        end
      end
      if (image_end_i) begin
        col_d    = '0;
        loaded_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      rt_q     <= '0;
      wt_q     <= '0;
      col_q    <= '0;
    end else begin
      loaded_q <= loaded_d;
      rt_q     <= rt_d;
      wt_q     <= wt_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
  end

  assign status_o.loaded      = loaded_q;
  assign status_o.row_total   = rt_q;
  assign status_o.white_total = wt_q;
  assign status_o.scan_clr    = pix_fire_i && (loaded_q || image_end_i);

endmodule
`default_nettype wire

### hw/rtl/rpls_scanner.sv
// Fetch sequencer: walks row counts from the RAM, tests each row against
// the mean threshold and returns text runs. Uses rpls_pkg and rpls_res_if.
`default_nettype none
module rpls_scanner (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fetch_fire_i,
  input  rpls_pkg::ldr_status_t              status_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rpls_pkg::RATIO_W-1:0]  cfg_wdata_i,
  input  wire logic [rpls_pkg::CNT_W-1:0]    ram_rdata_i,
  output logic                               ram_re_o,
  output logic      [rpls_pkg::ADDR_W-1:0]   ram_raddr_o,
  output logic                               accept_ok_o,
  rpls_res_if.source                         res_o
);
  import rpls_pkg::*;

  scan_state_e          state_q, state_d;
  logic [RATIO_W-1:0]   ratio_q;
  logic [RHS_W-1:0]     rhs_q;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [ROW_W-1:0]     r_q, r_d;
  logic [ROW_W-1:0]     first_q, first_d;
  logic [ROW_W-1:0]     scan_q, scan_d;
  logic                 ext_q, ext_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_has_q, out_has_d;
  logic [OUT_ROW_W-1:0] out_first_q, out_first_d;
  logic [OUT_ROW_W-1:0] out_last_q, out_last_d;
  logic                 out_done_q, out_done_d;

  logic [ROW_W-1:0]     r_inc;
  logic                 r_more;
  logic [CMP_W-1:0]     lhs;
  logic                 is_text;
  logic                 start_ok;

  assign r_inc    = r_q + ROW_W'(1);
  assign r_more   = r_inc < status_i.row_total;
  // count * rows * 10 as two shifted copies
  assign lhs      = (CMP_W'(prod_q) << 3) + (CMP_W'(prod_q) << 1);
  assign is_text  = lhs <= CMP_W'(rhs_q);
  assign start_ok = status_i.loaded && (scan_q < status_i.row_total);

  assign accept_ok_o = (state_q == SC_IDLE) && (!out_valid_q || res_o.ready);
  assign ram_re_o    = (state_q == SC_READ);
  assign ram_raddr_o = ADDR_W'(r_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SC_IDLE: begin
        if (fetch_fire_i && start_ok) begin
          state_d = SC_READ;
        end
      end
      SC_READ: state_d = SC_MULT;
      SC_MULT: state_d = SC_TEST;
      SC_TEST: begin
        if (r_more && (is_text || !ext_q)) begin
          state_d = SC_READ;
        end else begin
          state_d = SC_IDLE;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_comb begin
    r_d         = r_q;
    first_d     = first_q;
    scan_d      = scan_q;
    ext_d       = ext_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_has_d   = out_has_q;
    out_first_d = out_first_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    case (state_q)
      SC_IDLE: begin
        if (fetch_fire_i) begin
          if (start_ok) begin
            r_d   = scan_q;
            ext_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
            out_has_d   = 1'b0;
            out_first_d = '0;
            out_last_d  = '0;
            out_done_d  = 1'b1;
            if (status_i.loaded) begin
              scan_d = status_i.row_total;
            end
          end
        end
      end
      SC_READ: ;
      SC_MULT: prod_d = PROD_W'(ram_rdata_i) * PROD_W'(status_i.row_total);
      SC_TEST: begin
        if (is_text) begin
          if (!ext_q) begin
            first_d = r_q;
          end
          if (r_more) begin
            ext_d = 1'b1;
            r_d   = r_inc;
          end else begin
            out_valid_d = 1'b1;
            out_has_d   = 1'b1;
            out_first_d = OUT_ROW_W'(ext_q ? first_q : r_q);
            out_last_d  = OUT_ROW_W'(r_q);
            out_done_d  = 1'b0;
            scan_d      = r_inc;
          end
        end else if (ext_q) begin
          // run ends on the row before this one
          out_valid_d = 1'b1;
          out_has_d   = 1'b1;
          out_first_d = OUT_ROW_W'(first_q);
          out_last_d  = OUT_ROW_W'(r_q - ROW_W'(1));
          out_done_d  = 1'b0;
          scan_d      = r_q;
        end else if (r_more) begin
          r_d = r_inc;
        end else begin
          out_valid_d = 1'b1;
          out_has_d   = 1'b0;
          out_first_d = '0;
          out_last_d  = '0;
          out_done_d  = 1'b1;
          scan_d      = status_i.row_total;
        end
      end
      default: ;
    endcase
    if (status_i.scan_clr) begin
      scan_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SC_IDLE;
      ratio_q     <= RATIO_RESET;
      scan_q      <= '0;
      ext_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      ext_q       <= ext_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rhs_q       <= RHS_W'(ratio_q) * RHS_W'(status_i.white_total);
    prod_q      <= prod_d;
    r_q         <= r_d;
    first_q     <= first_d;
    out_has_q   <= out_has_d;
    out_first_q <= out_first_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.has_segment = out_has_q;
  assign res_o.first_row   = out_first_q;
  assign res_o.last_row    = out_last_q;
  assign res_o.scan_done   = out_done_q;

  a_unloaded_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_fire_i && !status_i.loaded |=> out_valid_q && out_done_q)
    else $error("fetch before load did not return done");

  a_seg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_has_q |-> out_first_q <= out_last_q)
    else $error("segment first row after last row");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_has_q != out_done_q)
    else $error("result is both or neither segment and done");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.loaded |-> scan_q <= status_i.row_total)
    else $error("scan row beyond row total");

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SC_READ |-> r_q < status_i.row_total)
    else $error("read of a row that was never closed");

endmodule
`default_nettype wire

### hw/rtl/row_projection_line_segmenter_core.sv
// Pixels: no result; one word per cycle while no fetch or result stalls.
// Fetch: result in the cycle after accept if no row is left; else per row:
// RAM read, count*rows multiply, threshold compare; then result register.
// Reset clears all control state; the row count RAM is not cleared, each
// entry is written when its row closes, before any fetch can read it.
`default_nettype none
module row_projection_line_segmenter_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rpls_pkg::RATIO_W-1:0] cfg_wdata_i,
  rpls_req_if.sink                          req_i,
  rpls_res_if.source                        res_o
);
  import rpls_pkg::*;

  ldr_status_t       status;
  ram_wr_t           ram_wr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;
  logic              accept_ok;
  logic              req_fire;

  assign req_i.ready = accept_ok;
  assign req_fire    = req_i.valid && accept_ok;

  rpls_loader u_loader (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_fire_i    (req_fire && (req_i.req_type == REQ_PIXEL)),
    .pixel_white_i (req_i.pixel_white),
    .row_end_i     (req_i.row_end),
    .image_end_i   (req_i.image_end),
    .ram_wr_o      (ram_wr),
    .status_o      (status)
  );

  rpls_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_ROWS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpls_scanner u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fetch_fire_i (req_fire && (req_i.req_type == REQ_FETCH)),
    .status_i     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .ram_rdata_i  (ram_rdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .accept_ok_o  (accept_ok),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for row_projection_line_segmenter_core: drives pixel and fetch words,
// predicts each fetch result from its own copy of the row counts, and checks every result.
// Depends on rpls_pkg, rpls_chan_if.sv and the core RTL.
`default_nettype none
module tb_top;
  import rpls_pkg::*;

  typedef struct packed {
    logic                 has_segment;
    logic [OUT_ROW_W-1:0] first_row;
    logic [OUT_ROW_W-1:0] last_row;
    logic                 scan_done;
  } seg_result_t;

  typedef struct packed {
    logic        req_type;
    logic        pixel_white;
    logic        row_end;
    logic        image_end;
    logic        pinned;
    seg_result_t pinned_res;
  } word_t;

  localparam seg_result_t DONE_RES = '{1'b0, 10'd0, 10'd0, 1'b1};
  localparam int          DIR_LEN  = 23;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RATIO_W-1:0] cfg_wdata_i = '0;

  rpls_req_if req_if ();
  rpls_res_if res_if ();

  row_projection_line_segmenter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state, same widths as the block
  logic [CNT_W-1:0]   row_counts [MAX_ROWS];
  logic [WT_W-1:0]    white_sum;
  logic [ROW_W-1:0]   rows_done;
  logic [ROW_W-1:0]   scan_ptr;
  logic               img_ready;
  logic [CNT_W-1:0]   col_pos;
  logic [RATIO_W-1:0] thr_ratio;

  word_t       pending_words [$];
  seg_result_t runs_due [$];
  word_t       cur_word;
  word_t       next_word;
  seg_result_t got_run;
  seg_result_t want_run;
  word_t       directed_tbl [DIR_LEN];

  int  pushed_cnt = 0;
  int  accepted_cnt = 0;
  int  err_cnt = 0;
  int  seg_seen = 0;
  int  done_seen = 0;
  int  image_cnt = 0;
  int  setting_cnt = 0;
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  logic stall_go = 1'b0;
  logic rcv_frozen = 1'b0;

  function automatic bit row_is_text(input int r);
    longint lhs;
    longint rhs;
    lhs = longint'(row_counts[r]) * longint'(rows_done) * 10;
    rhs = longint'(thr_ratio) * longint'(white_sum);
    return lhs <= rhs;
  endfunction

  function automatic void load_pixel(input logic pw, input logic re, input logic ie);
    if (img_ready) begin
      white_sum = '0;
      rows_done = '0;
      col_pos   = '0;
      scan_ptr  = '0;
      img_ready = 1'b0;
    end
    if (rows_done < MAX_ROWS) begin
      if (col_pos == 0) row_counts[rows_done[ADDR_W-1:0]] = '0;
      if (col_pos < MAX_COLS) begin
        col_pos = col_pos + CNT_W'(1);
        if (pw && row_counts[rows_done[ADDR_W-1:0]] < MAX_COLS) begin
          row_counts[rows_done[ADDR_W-1:0]] = row_counts[rows_done[ADDR_W-1:0]] + CNT_W'(1);
          white_sum = white_sum + WT_W'(1);
        end
      end
      if (re || (ie && col_pos > 0)) begin
        if (rows_done < MAX_ROWS) rows_done = rows_done + ROW_W'(1);
        col_pos = '0;
      end
    end
    if (ie) begin
      col_pos   = '0;
      scan_ptr  = '0;
      img_ready = 1'b1;
    end
  endfunction

  function automatic seg_result_t next_text_run();
    seg_result_t res;
    int r;
    int first;
    res = DONE_RES;
    if (!img_ready) return res;
    r = scan_ptr;
    while (r < rows_done && r < MAX_ROWS && !row_is_text(r)) r++;
    if (r >= rows_done || r >= MAX_ROWS) begin
      scan_ptr = rows_done;
      return res;
    end
    first = r;
    while (r + 1 < rows_done && r + 1 < MAX_ROWS && row_is_text(r + 1)) r++;
    scan_ptr = ROW_W'(r + 1);
    res.has_segment = 1'b1;
    res.first_row   = OUT_ROW_W'(first);
    res.last_row    = OUT_ROW_W'(r);
    res.scan_done   = 1'b0;
    return res;
  endfunction

  // Request side: predict on accept, then offer the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_PIXEL;
      req_if.pixel_white <= 1'b0;
      req_if.row_end     <= 1'b0;
      req_if.image_end   <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) row_counts[i] = '0;
      white_sum = '0;
      rows_done = '0;
      scan_ptr  = '0;
      img_ready = 1'b0;
      col_pos   = '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        accepted_cnt++;
        if (cur_word.req_type == REQ_FETCH) begin
          got_run = next_text_run();
          runs_due.push_back(cur_word.pinned ? cur_word.pinned_res : got_run);
        end else begin
          load_pixel(cur_word.pixel_white, cur_word.row_end, cur_word.image_end);
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_word           = pending_words.pop_front();
          cur_word           <= next_word;
          req_if.valid       <= 1'b1;
          req_if.req_type    <= next_word.req_type;
          req_if.pixel_white <= next_word.pixel_white;
          req_if.row_end     <= next_word.row_end;
          req_if.image_end   <= next_word.image_end;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each word with the oldest expected run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (runs_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result seg=%0b first=%0d last=%0d done=%0b", $time,
                   res_if.has_segment, res_if.first_row, res_if.last_row, res_if.scan_done);
        end else begin
          want_run = runs_due.pop_front();
          if (res_if.has_segment !== want_run.has_segment) begin
            err_cnt++;
            $display("%0t: has_segment expected %0b actual %0b", $time,
                     want_run.has_segment, res_if.has_segment);
          end
          if (res_if.first_row !== want_run.first_row) begin
            err_cnt++;
            $display("%0t: first_row expected %0d actual %0d", $time,
                     want_run.first_row, res_if.first_row);
          end
          if (res_if.last_row !== want_run.last_row) begin
            err_cnt++;
            $display("%0t: last_row expected %0d actual %0d", $time,
                     want_run.last_row, res_if.last_row);
          end
          if (res_if.scan_done !== want_run.scan_done) begin
            err_cnt++;
            $display("%0t: scan_done expected %0b actual %0b", $time,
                     want_run.scan_done, res_if.scan_done);
          end
          if (want_run.has_segment) seg_seen++;
          else done_seen++;
        end
      end
      res_if.ready <= !rcv_frozen && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (stall_go);
    @(posedge clk_i);
    rcv_frozen <= 1'b1;
    repeat (600) @(posedge clk_i);
    rcv_frozen <= 1'b0;
  end

  initial begin
    #(20 * 1000000);
    $display("row_projection_line_segmenter_core test failed");
    $finish;
  end

  function automatic word_t mk(input logic rt, input logic pw, input logic re,
                               input logic ie, input logic pin);
    word_t w;
    w.req_type    = rt;
    w.pixel_white = pw;
    w.row_end     = re;
    w.image_end   = ie;
    w.pinned      = pin;
    w.pinned_res  = DONE_RES;
    return w;
  endfunction

  task automatic push_word(input word_t w);
    while (pending_words.size() >= 4) @(negedge clk_i);
    pending_words.push_back(w);
    pushed_cnt++;
  endtask

  task automatic send(input logic rt, input logic pw, input logic re, input logic ie);
    push_word(mk(rt, pw, re, ie, 1'b0));
  endtask

  task automatic fetch_burst(input int n);
    for (int i = 0; i < n; i++)
      send(REQ_FETCH, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Hold the sender until every word is in and every result is out
  task automatic drain();
    while (accepted_cnt != pushed_cnt || runs_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    thr_ratio  = v;
    setting_cnt++;
    @(negedge clk_i);
  endtask

  task automatic stream_image(input int n_rows, input int col_max, input int mode);
    int  ncol;
    int  dens;
    bit  partial;
    bit  last_px;
    bit  last_row;
    partial = $urandom_range(1);
    for (int r = 0; r < n_rows; r++) begin
      ncol = $urandom_range(col_max, 1);
      case (mode)
        0: dens = 0;
        1: dens = 100;
        default: begin
          case ($urandom_range(4))
            0: dens = 0;
            1: dens = 20;
            2: dens = 50;
            3: dens = 80;
            default: dens = 100;
          endcase
        end
      endcase
      for (int c = 0; c < ncol; c++) begin
        last_px  = (c == ncol - 1);
        last_row = (r == n_rows - 1);
        // stray fetch while the image is still loading
        if ($urandom_range(99) < 3) fetch_burst(1);
        send(REQ_PIXEL, 1'($urandom_range(99) < dens), last_px && !(last_row && partial),
             last_px && last_row);
      end
    end
    image_cnt++;
  endtask

  initial begin
    int start_cnt;
    int n_rows;
    thr_ratio = RATIO_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fetch before load, one image with a run in the middle, a dark image with a partial
    // last row, a fetch during loading, and a one-row image whose run reaches the bottom
    directed_tbl = '{
      mk(REQ_FETCH, 0, 0, 0, 1), mk(REQ_FETCH, 1, 1, 1, 1),
      mk(REQ_PIXEL, 1, 0, 0, 0), mk(REQ_PIXEL, 1, 1, 0, 0),
      mk(REQ_PIXEL, 0, 0, 0, 0), mk(REQ_PIXEL, 0, 1, 0, 0),
      mk(REQ_PIXEL, 0, 1, 0, 0),
      mk(REQ_PIXEL, 1, 0, 0, 0), mk(REQ_PIXEL, 1, 0, 0, 0), mk(REQ_PIXEL, 1, 1, 1, 0),
      mk(REQ_FETCH, 0, 0, 0, 0), mk(REQ_FETCH, 0, 0, 0, 0), mk(REQ_FETCH, 1, 0, 1, 0),
      mk(REQ_PIXEL, 0, 0, 0, 0), mk(REQ_PIXEL, 0, 1, 0, 0), mk(REQ_PIXEL, 0, 0, 1, 0),
      mk(REQ_FETCH, 0, 0, 0, 0), mk(REQ_FETCH, 0, 0, 0, 0),
      mk(REQ_PIXEL, 1, 0, 0, 0), mk(REQ_FETCH, 0, 1, 0, 1),
      mk(REQ_PIXEL, 1, 1, 1, 0), mk(REQ_FETCH, 0, 0, 0, 0), mk(REQ_FETCH, 0, 0, 0, 0)
    };
    for (int i = 0; i < DIR_LEN; i++) push_word(directed_tbl[i]);

    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0:       write_ratio(RATIO_W'(1));
        1:       write_ratio(RATIO_W'(40));
        default: write_ratio(RATIO_W'($urandom_range(40, 1)));
      endcase
      src_idle_pct = (blk < 2) ? 24 : (blk < 4) ? 50 : 0;
      snk_idle_pct = (blk < 2) ? 50 : (blk < 4) ? 24 : 0;
      if (blk == 0) begin
        stall_go = 1'b1;
        stream_image(6, 4, 2);
        fetch_burst(30);
      end
      // more fetches on the previous image under the new threshold
      fetch_burst(3);
      start_cnt = pushed_cnt;
      while (pushed_cnt - start_cnt < 20) begin
        n_rows = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
        stream_image(n_rows, ($urandom_range(4) == 0) ? 12 : 4, $urandom_range(9));
        if ($urandom_range(9) != 0) fetch_burst($urandom_range(10, 1));
      end
    end

    // more rows than the block holds; the dark stretch after the last white rows
    // reaches the bottom
    write_ratio(RATIO_RESET);
    for (int i = 0; i < MAX_ROWS + 6; i++)
      send(REQ_PIXEL, 1'((i % 128) < 3), 1'b1, 1'(i == MAX_ROWS + 5));
    image_cnt++;
    fetch_burst(10);

    drain();
    repeat (50) @(negedge clk_i);

    $display("Run covered %0d images and %0d words under %0d threshold settings,", image_cnt,
             accepted_cnt, setting_cnt);
    $display("with %0d segment and %0d done results checked.", seg_seen, done_seen);
    if (err_cnt == 0 && runs_due.size() == 0) begin
      $display("row_projection_line_segmenter_core test passed");
    end else begin
      $display("row_projection_line_segmenter_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
